// File: design/weighted_moving_average_macros.svh
// Assertion macros for the weighted moving average block.
// Depends on a clock named clock and a synchronous active-high reset named reset.
`ifndef WEIGHTED_MOVING_AVERAGE_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define WMA_CHECK_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("weighted moving average check failed");

// The consequent holds in the cycle after the antecedent.
`define WMA_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("weighted moving average check failed");

// The expression holds in every cycle out of reset.
`define WMA_CHECK_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("weighted moving average check failed");

`endif

// File: design/wma_pkg.sv
// Shared constants, controller states and command/status types of the weighted moving average.
// No dependencies.
`timescale 1ns / 1ps

package wma_pkg;

   localparam int MaxWindowDefault  = 32;
   localparam int SampleBitsDefault = 32;
   localparam int TagBits           = 32;
   localparam int CfgBits           = 6;
   localparam int CsrDataBits       = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_SUM,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } wma_state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic mult;
      logic update;
      logic div_start;
      logic div_step;
      logic out_load;
   } wma_cmd_type;

   typedef struct packed {
      logic yields;
      logic div_last;
      logic out_free;
   } wma_status_type;

endpackage

// File: design/weighted_moving_average.sv
// Top level of the linear weighted moving average over a sliding window of signed samples.
// Depends on wma_pkg, wma_ctrl, wma_datapath, wma_ram and weighted_moving_average_macros.svh.
//
//   Channel   Direction  Contents
//   req_*     in         sample_value (low bits), sample_tag
//   rsp_*     out        average_value (low bits), result_tag
//   csr_*     in         window_length (low six bits)
//
// A request without a result passes ST_IDLE, ST_MULT and ST_SUM; one with a result then also passes
// ST_LOAD, ST_DIV and ST_OUT, with the one-bit-a-cycle divider working in ST_DIV.
// Reset is synchronous; it empties the window and sets the window length to one.
// A result waits in the output register while requests go on; a newer one stalls until it is read.
// A length write is taken only between requests and empties the window.
`timescale 1ns / 1ps
`include "weighted_moving_average_macros.svh"

module weighted_moving_average import wma_pkg::*; #(
   parameter int MAX_WINDOW  = MaxWindowDefault,
   parameter int SAMPLE_BITS = SampleBitsDefault
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // sample_value, sample_tag, zero padding
   input  logic [((SAMPLE_BITS+TagBits+7)/8)*8-1:0] req_tdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // average_value, result_tag, zero padding
   output logic [((SAMPLE_BITS+TagBits+7)/8)*8-1:0] rsp_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // window_length, zero padding
   input  logic [CsrDataBits-1:0]                   csr_tdata,
   input  logic                                     csr_tvalid,
   output logic                                     csr_tready
);

   wma_cmd_type    cmd;
   wma_status_type status;

   wma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .csr_tvalid (csr_tvalid),
      .status     (status),
      .req_tready (req_tready),
      .csr_tready (csr_tready),
      .cmd        (cmd)
   );

   wma_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_tdata  (csr_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `WMA_CHECK_ALWAYS(a_cfg_req_apart, !(csr_tvalid && csr_tready && req_tvalid && req_tready))
   `WMA_CHECK_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)
   `WMA_CHECK_IMPLY(a_no_overwrite, cmd.out_load, !rsp_tvalid || rsp_tready)
   `WMA_CHECK_ALWAYS(a_one_command, $onehot0(cmd))

endmodule

// File: design/wma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/wma_ctrl.sv
// Controller state machine of the weighted moving average.
// Depends on wma_pkg for its states and the command and status types.
`timescale 1ns / 1ps

module wma_ctrl import wma_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           csr_tvalid,
   input  wma_status_type status,
   output logic           req_tready,
   output logic           csr_tready,
   output wma_cmd_type    cmd
);

   wma_state_type state_ff;
   wma_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      csr_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            csr_tready = 1'b1;
            req_tready = !csr_tvalid;
            if (csr_tvalid) begin
               cmd.clear = 1'b1;
            end else if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.update = 1'b1;
            state_in   = status.yields ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/wma_datapath.sv
// Datapath of the weighted moving average: window RAM, running sums, serial divider, result register.
// Depends on wma_pkg and wma_ram.
`timescale 1ns / 1ps

module wma_datapath import wma_pkg::*; #(
   parameter int MAX_WINDOW  = MaxWindowDefault,
   parameter int SAMPLE_BITS = SampleBitsDefault
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  wma_cmd_type                                 cmd,
   output wma_status_type                              status,
   input  logic [((SAMPLE_BITS+TagBits+7)/8)*8-1:0]    req_tdata,
   input  logic [CsrDataBits-1:0]                      csr_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [((SAMPLE_BITS+TagBits+7)/8)*8-1:0]    rsp_tdata
);

   localparam int DataBits = ((SAMPLE_BITS + TagBits + 7) / 8) * 8;
   localparam int NBits    = $clog2(MAX_WINDOW + 1);
   localparam int PosBits  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int TotalMax = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
   localparam int TBits    = $clog2(TotalMax + 1);
   localparam int RsBits   = SAMPLE_BITS + NBits;
   localparam int WsBits   = SAMPLE_BITS + TBits;
   localparam int CntBits  = $clog2(WsBits);

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [TagBits-1:0]            tag_ff;
   logic signed [WsBits-1:0]      prod_ff;
   logic signed [RsBits-1:0]      running_ff;
   logic signed [WsBits-1:0]      weighted_ff;
   logic [NBits-1:0]              fill_ff;
   logic [PosBits-1:0]            pos_ff;
   logic [NBits-1:0]              n_ff;
   logic [TBits-1:0]              total_ff;
   logic [WsBits-1:0]             mag_ff;
   logic [TBits-1:0]              rem_ff;
   logic                          neg_ff;
   logic [CntBits-1:0]            cnt_ff;
   logic signed [SAMPLE_BITS-1:0] avg_ff;
   logic [TagBits-1:0]            rtag_ff;
   logic                          out_valid_ff;

   logic signed [RsBits-1:0]      running_in;
   logic signed [WsBits-1:0]      weighted_in;
   logic [NBits-1:0]              fill_in;
   logic [PosBits-1:0]            pos_in;
   logic [WsBits-1:0]             mag_in;
   logic [TBits-1:0]              rem_in;
   logic [WsBits-1:0]             quot;

   logic                          full;
   logic [NBits-1:0]              fill_next;
   logic [NBits-1:0]              k;
   logic signed [RsBits:0]        prod_full;
   logic [SAMPLE_BITS-1:0]        oldest_raw;
   logic signed [SAMPLE_BITS-1:0] oldest;
   logic [TBits:0]                trial;
   logic                          trial_ge;

   logic [CfgBits-1:0]            cfg_raw;
   logic [NBits-1:0]              cfg_n;
   logic [2*NBits:0]              cfg_prod;
   logic [TBits-1:0]              cfg_total;

   wma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (pos_ff),
      .wr_data (x_ff),
      .rd_en   (cmd.load),
      .rd_addr (pos_ff),
      .rd_data (oldest_raw)
   );

   assign oldest    = $signed(oldest_raw);
   assign full      = (fill_ff == n_ff);
   assign fill_next = fill_ff + NBits'(1);
   assign k         = full ? n_ff : fill_next;
   assign prod_full = $signed({1'b0, k}) * x_ff;

   always_comb begin
      if (full) begin
         running_in  = running_ff - RsBits'(oldest) + RsBits'(x_ff);
         weighted_in = weighted_ff - WsBits'(running_ff) + prod_ff;
         fill_in     = fill_ff;
      end else begin
         running_in  = running_ff + RsBits'(x_ff);
         weighted_in = weighted_ff + prod_ff;
         fill_in     = fill_next;
      end
      if (NBits'(pos_ff) + NBits'(1) == n_ff) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + PosBits'(1);
      end
   end

   assign mag_in   = weighted_ff[WsBits-1] ? WsBits'(-weighted_ff) : WsBits'(weighted_ff);
   assign trial    = {rem_ff, mag_ff[WsBits-1]};
   assign trial_ge = (trial >= {1'b0, total_ff});
   assign rem_in   = trial_ge ? TBits'(trial - {1'b0, total_ff}) : trial[TBits-1:0];
   assign quot     = neg_ff ? (~mag_ff + WsBits'(1)) : mag_ff;

   always_comb begin
      cfg_raw = csr_tdata[CfgBits-1:0];
      if (cfg_raw == '0) begin
         cfg_n = NBits'(1);
      end else if (32'(cfg_raw) > 32'(MAX_WINDOW)) begin
         cfg_n = NBits'(MAX_WINDOW);
      end else begin
         cfg_n = NBits'(cfg_raw);
      end
      cfg_prod  = (2*NBits+1)'(cfg_n) * ((2*NBits+1)'(cfg_n) + (2*NBits+1)'(1));
      cfg_total = TBits'(cfg_prod >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         weighted_ff  <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         n_ff         <= NBits'(1);
         total_ff     <= TBits'(1);
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            running_ff  <= '0;
            weighted_ff <= '0;
            fill_ff     <= '0;
            pos_ff      <= '0;
            n_ff        <= cfg_n;
            total_ff    <= cfg_total;
         end else if (cmd.update) begin
            running_ff  <= running_in;
            weighted_ff <= weighted_in;
            fill_ff     <= fill_in;
            pos_ff      <= pos_in;
         end
         if (cmd.div_start) begin
            cnt_ff <= CntBits'(WsBits - 1);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - CntBits'(1);
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= $signed(req_tdata[SAMPLE_BITS-1:0]);
         tag_ff <= req_tdata[SAMPLE_BITS +: TagBits];
      end
      if (cmd.mult) begin
         prod_ff <= WsBits'(prod_full);
      end
      if (cmd.div_start) begin
         mag_ff <= mag_in;
         neg_ff <= weighted_ff[WsBits-1];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         mag_ff <= {mag_ff[WsBits-2:0], trial_ge};
         rem_ff <= rem_in;
      end
      if (cmd.out_load) begin
         avg_ff  <= $signed(quot[SAMPLE_BITS-1:0]);
         rtag_ff <= tag_ff;
      end
   end

   assign status.yields   = full || (fill_next == n_ff);
   assign status.div_last = (cnt_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DataBits'({rtag_ff, avg_ff});

endmodule
